// ===== src/imd_pkg.sv =====
// ---------------------------------------------------------------------------
// imd_pkg: shared constants for the impact detector
// Sample and time widths, register indexes and derived datapath widths.
// ---------------------------------------------------------------------------
package imd_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int TIME_BITS   = 32;
  localparam int CFG_BITS    = 16;
  localparam int CHANGE_BITS = 34;
  localparam int DIR_BITS    = 2;

  localparam int DIFF_BITS = SAMPLE_BITS + 1;
  localparam int SQ_BITS   = 2 * DIFF_BITS;
  localparam int SUM_BITS  = SQ_BITS + 2;
  localparam int THR2_BITS = 2 * CFG_BITS;
  localparam int CMP_BITS  = (SUM_BITS > CHANGE_BITS) ? SUM_BITS : CHANGE_BITS;

  typedef logic [1:0] cfg_index_t;

  localparam cfg_index_t REG_DELTA_THRESHOLD = 2'd0;
  localparam cfg_index_t REG_CONFIRM_TIME    = 2'd1;
  localparam cfg_index_t REG_COOLDOWN_TIME   = 2'd2;

  typedef logic [DIR_BITS-1:0] dir_t;

  localparam dir_t DIR_LEFT  = 2'd0;
  localparam dir_t DIR_RIGHT = 2'd1;
  localparam dir_t DIR_BACK  = 2'd2;
  localparam dir_t DIR_FRONT = 2'd3;

  localparam logic [CFG_BITS-1:0] DELTA_THRESHOLD_RESET = 16'd1000;
  localparam logic [CFG_BITS-1:0] CONFIRM_TIME_RESET    = 16'd35;
  localparam logic [CFG_BITS-1:0] COOLDOWN_TIME_RESET   = 16'd1000;

  // Impact direction from the dominant horizontal axis.
  function automatic dir_t impact_dir(input logic signed [SAMPLE_BITS-1:0] x,
                                      input logic signed [SAMPLE_BITS-1:0] y);
    logic signed [DIFF_BITS-1:0] xs;
    logic signed [DIFF_BITS-1:0] ys;
    logic [DIFF_BITS-1:0]        mx;
    logic [DIFF_BITS-1:0]        my;
    dir_t                        d;
    xs = DIFF_BITS'(x);
    ys = DIFF_BITS'(y);
    mx = xs[DIFF_BITS-1] ? DIFF_BITS'(-xs) : DIFF_BITS'(xs);
    my = ys[DIFF_BITS-1] ? DIFF_BITS'(-ys) : DIFF_BITS'(ys);
    if (mx > my) begin
      d = (x > 0) ? DIR_LEFT : DIR_RIGHT;
    end else begin
      d = (y > 0) ? DIR_BACK : DIR_FRONT;
    end
    return d;
  endfunction

endpackage

// ===== src/impact_detector.sv =====
// ---------------------------------------------------------------------------
// impact_detector: crash detection on a three-axis accelerometer stream
// Squared sample-to-sample change against a threshold, confirm and cooldown.
// ---------------------------------------------------------------------------
// One sample can be taken every clock while the input does not stall. A sample
// is registered in the input register on accept and evaluated from there
// (three squarers, a sum and a compare against the threshold squared); a crash
// result is then registered in the output register. The input stalls only while
// a result sits in the output register and the output side is stalling.
module impact_detector (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  imd_pkg::cfg_index_t                   cfg_index,
  input  logic [imd_pkg::CFG_BITS-1:0]          cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [imd_pkg::SAMPLE_BITS-1:0] accel_x,
  input  logic signed [imd_pkg::SAMPLE_BITS-1:0] accel_y,
  input  logic signed [imd_pkg::SAMPLE_BITS-1:0] accel_z,
  input  logic [imd_pkg::TIME_BITS-1:0]         sample_time_ms,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [imd_pkg::DIR_BITS-1:0]          impact_direction,
  output logic signed [imd_pkg::SAMPLE_BITS-1:0] crash_x,
  output logic signed [imd_pkg::SAMPLE_BITS-1:0] crash_y,
  output logic signed [imd_pkg::SAMPLE_BITS-1:0] crash_z,
  output logic [imd_pkg::CHANGE_BITS-1:0]       change_squared
);
  import imd_pkg::*;

  logic [CFG_BITS-1:0] delta_threshold;
  logic [CFG_BITS-1:0] confirm_time_ms;
  logic [CFG_BITS-1:0] cooldown_time_ms;

  // input register
  logic                          s1_valid;
  logic signed [SAMPLE_BITS-1:0] s1_x;
  logic signed [SAMPLE_BITS-1:0] s1_y;
  logic signed [SAMPLE_BITS-1:0] s1_z;
  logic [TIME_BITS-1:0]          s1_t;

  // detector state
  logic signed [SAMPLE_BITS-1:0] last_x;
  logic signed [SAMPLE_BITS-1:0] last_y;
  logic signed [SAMPLE_BITS-1:0] last_z;
  logic                          have_last;
  logic                          candidate_open;
  logic [TIME_BITS-1:0]          candidate_start;
  logic [TIME_BITS-1:0]          last_crash_time;
  logic                          crashed_before;

  logic                          blocked;
  logic                          advance;
  logic                          in_accept;

  logic [DIFF_BITS-1:0]          dx;
  logic [DIFF_BITS-1:0]          dy;
  logic [DIFF_BITS-1:0]          dz;
  logic [SUM_BITS-1:0]           sum_sq;
  logic [CMP_BITS-1:0]           change;
  logic [THR2_BITS-1:0]          thr2;
  logic                          over;
  logic [TIME_BITS-1:0]          start_eff;
  logic [TIME_BITS-1:0]          run_ms;
  logic [TIME_BITS-1:0]          since_ms;
  logic                          crash;

  function automatic logic [DIFF_BITS-1:0] abs_diff(
    input logic signed [SAMPLE_BITS-1:0] a,
    input logic signed [SAMPLE_BITS-1:0] b
  );
    logic signed [DIFF_BITS-1:0] d;
    d = DIFF_BITS'(a) - DIFF_BITS'(b);
    return d[DIFF_BITS-1] ? DIFF_BITS'(-d) : DIFF_BITS'(d);
  endfunction

  assign blocked   = out_valid && out_stall;
  assign in_stall  = s1_valid && blocked;
  assign in_accept = in_valid && !in_stall;
  assign advance   = s1_valid && !blocked;

  assign dx = abs_diff(s1_x, last_x);
  assign dy = abs_diff(s1_y, last_y);
  assign dz = abs_diff(s1_z, last_z);

  assign sum_sq = SUM_BITS'(SQ_BITS'(dx) * SQ_BITS'(dx))
                + SUM_BITS'(SQ_BITS'(dy) * SQ_BITS'(dy))
                + SUM_BITS'(SQ_BITS'(dz) * SQ_BITS'(dz));
  assign change = CMP_BITS'(sum_sq);
  assign thr2   = THR2_BITS'(delta_threshold) * THR2_BITS'(delta_threshold);
  assign over   = have_last && (change > CMP_BITS'(thr2));

  // a new run starts at this sample unless a candidate run is already open
  assign start_eff = candidate_open ? candidate_start : s1_t;
  assign run_ms    = s1_t - start_eff;
  assign since_ms  = s1_t - last_crash_time;
  assign crash     = over && (run_ms >= TIME_BITS'(confirm_time_ms))
                  && (!crashed_before || since_ms >= TIME_BITS'(cooldown_time_ms));

  always_ff @(posedge clk) begin
    if (rst) begin
      delta_threshold  <= DELTA_THRESHOLD_RESET;
      confirm_time_ms  <= CONFIRM_TIME_RESET;
      cooldown_time_ms <= COOLDOWN_TIME_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DELTA_THRESHOLD: delta_threshold  <= cfg_data;
        REG_CONFIRM_TIME:    confirm_time_ms  <= cfg_data;
        REG_COOLDOWN_TIME:   cooldown_time_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_x <= accel_x;
      s1_y <= accel_y;
      s1_z <= accel_z;
      s1_t <= sample_time_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_x          <= '0;
      last_y          <= '0;
      last_z          <= '0;
      have_last       <= 1'b0;
      candidate_open  <= 1'b0;
      candidate_start <= '0;
      last_crash_time <= '0;
      crashed_before  <= 1'b0;
    end else if (advance) begin
      last_x    <= s1_x;
      last_y    <= s1_y;
      last_z    <= s1_z;
      have_last <= 1'b1;
      if (!have_last) begin
        // first sample is only stored
      end else if (crash || !over) begin
        candidate_open  <= 1'b0;
        candidate_start <= '0;
      end else begin
        candidate_open  <= 1'b1;
        candidate_start <= start_eff;
      end
      if (crash) begin
        last_crash_time <= s1_t;
        crashed_before  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && crash) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && crash) begin
      impact_direction <= impact_dir(s1_x, s1_y);
      crash_x          <= s1_x;
      crash_y          <= s1_y;
      crash_z          <= s1_z;
      change_squared   <= change[CHANGE_BITS-1:0];
    end
  end

endmodule

// ===== src/imd_checker.sv =====
// ---------------------------------------------------------------------------
// imd_checker: port-level checks for the impact detector
// Output handshake and consistency of the reported crash.
// ---------------------------------------------------------------------------
module imd_checker (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  out_valid,
  input  logic                                  out_stall,
  input  logic [imd_pkg::DIR_BITS-1:0]          impact_direction,
  input  logic signed [imd_pkg::SAMPLE_BITS-1:0] crash_x,
  input  logic signed [imd_pkg::SAMPLE_BITS-1:0] crash_y,
  input  logic [imd_pkg::CHANGE_BITS-1:0]       change_squared
);
  import imd_pkg::*;

  dir_t exp_dir;

  assign exp_dir = impact_dir(crash_x, crash_y);

  // a stalled result stays, with its change and x sample unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(change_squared) && $stable(crash_x))
    else $error("stalled result dropped or changed");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

  // the direction follows the reported sample
  a_dir: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> impact_direction == exp_dir)
    else $error("impact direction does not match crash sample");

  // a crash change is strictly above a non-negative threshold squared, so never zero
  a_change_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> change_squared != '0)
    else $error("crash reported with zero change");

endmodule

bind impact_detector imd_checker u_imd_checker (.*);
